/* design/nacs_pkg.sv */
// Package for the NAND address cycle sequencer.
// Holds command codes, the bus cycle slot and request descriptor types, and the
// configuration bundle. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nacs_pkg;

    localparam int SLOT_COUNT = 7;
    localparam int COUNT_W    = 3;

    localparam logic [7:0] CMD_READ0     = 8'h00;
    localparam logic [7:0] CMD_READOOB   = 8'h50;
    localparam logic [7:0] CMD_READSTART = 8'h30;
    localparam logic [7:0] CMD_ERASE1    = 8'h60;
    localparam logic [7:0] CMD_ERASE2    = 8'hD0;

    localparam logic [7:0] COL_SPARE_HI  = 8'h08;

    localparam logic [1:0] REG_LARGE_PAGE  = 2'd0;
    localparam logic [1:0] REG_ADDR_CYCLES = 2'd1;
    localparam logic [1:0] REG_BLOCK_SHIFT = 2'd2;

    localparam logic       OP_PAGE_ACCESS = 1'b0;
    localparam logic       OP_BLOCK_ERASE = 1'b1;

    typedef struct packed {
        logic       is_cmd;
        logic [7:0] data;
    } slot_t;

    typedef struct packed {
        slot_t [SLOT_COUNT-1:0] slots;
        logic [COUNT_W-1:0]     count;
    } desc_t;

    typedef struct packed {
        logic       large_page;
        logic [2:0] addr_cycles;
        logic [3:0] block_shift;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

/* design/nacs_front.sv */
// Front part of the NAND address cycle sequencer.
// Classifies one request and lays out its bus cycles into a descriptor.
// Depends on nacs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nacs_front
    import nacs_pkg::*;
(
    input  var cfg_t        cfg,
    input  wire             opcode,
    input  wire [7:0]       command_byte,
    input  wire [31:0]      page_number,
    input  wire [21:0]      block_number,
    input  wire             spare_only,
    output desc_t           desc
);

    logic [31:0]        row;
    logic [7:0]         cmd_eff;
    logic [COUNT_W-1:0] idx;

    always_comb
    begin
        desc = '0;
        idx  = '0;
        if (opcode == OP_BLOCK_ERASE)
        begin
            row = {10'd0, block_number} << cfg.block_shift;
        end
        else
        begin
            row = page_number;
        end
        cmd_eff = command_byte;
        if (!cfg.large_page && spare_only && (command_byte == CMD_READ0))
        begin
            cmd_eff = CMD_READOOB;
        end

        if (opcode == OP_BLOCK_ERASE)
        begin
            desc.slots[idx] = '{is_cmd: 1'b1, data: CMD_ERASE1};
            idx = idx + 3'd1;
        end
        else
        begin
            desc.slots[idx] = '{is_cmd: 1'b1, data: cmd_eff};
            idx = idx + 3'd1;
            desc.slots[idx] = '{is_cmd: 1'b0, data: 8'h00};
            idx = idx + 3'd1;
            if (cfg.large_page)
            begin
                desc.slots[idx] = '{is_cmd: 1'b0, data: (spare_only ? COL_SPARE_HI : 8'h00)};
                idx = idx + 3'd1;
            end
        end

        desc.slots[idx] = '{is_cmd: 1'b0, data: row[7:0]};
        idx = idx + 3'd1;
        desc.slots[idx] = '{is_cmd: 1'b0, data: row[15:8]};
        idx = idx + 3'd1;
        if (cfg.large_page)
        begin
            if (cfg.addr_cycles >= 3'd5)
            begin
                desc.slots[idx] = '{is_cmd: 1'b0, data: row[23:16]};
                idx = idx + 3'd1;
            end
        end
        else
        begin
            if (cfg.addr_cycles >= 3'd4)
            begin
                desc.slots[idx] = '{is_cmd: 1'b0, data: row[23:16]};
                idx = idx + 3'd1;
            end
            if (cfg.addr_cycles >= 3'd5)
            begin
                desc.slots[idx] = '{is_cmd: 1'b0, data: row[31:24]};
                idx = idx + 3'd1;
            end
        end

        if (opcode == OP_BLOCK_ERASE)
        begin
            desc.slots[idx] = '{is_cmd: 1'b1, data: CMD_ERASE2};
            idx = idx + 3'd1;
        end
        else if (cfg.large_page && (command_byte == CMD_READ0))
        begin
            desc.slots[idx] = '{is_cmd: 1'b1, data: CMD_READSTART};
            idx = idx + 3'd1;
        end

        desc.count = idx;
    end

endmodule

`default_nettype wire

/* design/nacs_queue.sv */
// Two-entry descriptor queue between the front and back parts.
// Depends on nacs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nacs_queue
    import nacs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    input  var desc_t  push_desc,
    input  wire        pop,
    output desc_t      head,
    output q_status_t  status
);

    desc_t      entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

/* design/nacs_back.sv */
// Back part of the NAND address cycle sequencer.
// Walks the head descriptor one bus cycle per beat into the output register.
// Depends on nacs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nacs_back
    import nacs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  var desc_t  head,
    input  wire        q_empty,
    output logic       pop,
    output logic       out_valid,
    input  wire        out_stall,
    output logic       is_command,
    output logic [7:0] bus_byte,
    output logic       last_cycle
);

    logic [COUNT_W-1:0] pos_reg;
    logic [COUNT_W-1:0] pos_next;
    logic               valid_reg;
    logic               valid_next;
    logic               is_cmd_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic               advance;
    logic               is_last;
    slot_t              cur;

    always_comb
    begin
        advance = !q_empty && (!valid_reg || !out_stall);
        cur     = head.slots[pos_reg];
        is_last = (pos_reg == (head.count - 3'd1));
        pop     = advance && is_last;
        if (advance)
        begin
            pos_next   = is_last ? '0 : pos_reg + 3'd1;
            valid_next = 1'b1;
        end
        else
        begin
            pos_next   = pos_reg;
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            is_cmd_reg <= cur.is_cmd;
            byte_reg   <= cur.data;
            last_reg   <= is_last;
        end
    end

    assign out_valid  = valid_reg;
    assign is_command = is_cmd_reg;
    assign bus_byte   = byte_reg;
    assign last_cycle = last_reg;

endmodule

`default_nettype wire

/* design/nand_address_cycle_sequencer.sv */
// NAND address cycle sequencer: turns page access and block erase requests into beats.
// The first beat of a request passes through the queue, then the output register.
// Beats leave the single output register one per cycle while out_stall is low; a
// request has 4 to 7 beats, and queued requests follow one another without gaps.
// Reset: clears the queue and output valid; config becomes large_page 0,
// addr_cycles 4, block_shift 5. Depends on nacs_pkg and the nacs_* modules.
`timescale 1ns / 1ps
`default_nettype none

module nand_address_cycle_sequencer
    import nacs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_write,
    input  wire [1:0]  cfg_index,
    input  wire [3:0]  cfg_data,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire        opcode,
    input  wire [7:0]  command_byte,
    input  wire [31:0] page_number,
    input  wire [21:0] block_number,
    input  wire        spare_only,
    output logic       out_valid,
    input  wire        out_stall,
    output logic       is_command,
    output logic [7:0] bus_byte,
    output logic       last_cycle
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    desc_t     front_desc;
    desc_t     head;
    q_status_t q_status;
    logic      q_push;
    logic      q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LARGE_PAGE:  cfg_next.large_page  = cfg_data[0];
                REG_ADDR_CYCLES: cfg_next.addr_cycles = cfg_data[2:0];
                REG_BLOCK_SHIFT: cfg_next.block_shift = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{large_page: 1'b0, addr_cycles: 3'd4, block_shift: 4'd5};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nacs_front u_front (
        .cfg          (cfg_reg),
        .opcode       (opcode),
        .command_byte (command_byte),
        .page_number  (page_number),
        .block_number (block_number),
        .spare_only   (spare_only),
        .desc         (front_desc)
    );

    assign in_stall = q_status.full;
    assign q_push   = in_valid && !q_status.full;

    nacs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (front_desc),
        .pop       (q_pop),
        .head      (head),
        .status    (q_status)
    );

    nacs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_status.empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_command (is_command),
        .bus_byte   (bus_byte),
        .last_cycle (last_cycle)
    );

    a_pop_loads_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && last_cycle))
        else $error("Queue pop did not load the final beat of a request.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("Queue popped while empty.");

    a_desc_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (front_desc.count >= 3'd4))
        else $error("Request laid out with too few bus cycles.");

endmodule

`default_nettype wire
